// ----- design/line_sensor_normalize_and_position_top_assert.svh -----
// Assertion macros for the line sensor normalize and position block.
// Included by the top level only.
`ifndef LINE_SENSOR_NORMALIZE_AND_POSITION_TOP_ASSERT_SVH
`define LINE_SENSOR_NORMALIZE_AND_POSITION_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LSNP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lsnp_pkg.sv -----
// Package for the line sensor normalize and position block.
// Types and fixed constants; no dependencies.
package lsnp_pkg;

    localparam int SAMPLE_W = 12;
    localparam int POS_W    = 13;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_SPREAD_MAX = 3'd0;
    localparam logic [IDX_W-1:0] REG_WHITE_MAX  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLACK_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_NOISE      = 3'd3;
    localparam logic [IDX_W-1:0] REG_DARK_LOW   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DARK_HIGH  = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNUSED     = 3'd7;

    localparam logic [POS_W-1:0] CENTER_POS = 13'd3500;
    localparam logic [POS_W-1:0] POS_MAX    = 13'd8191;
    localparam int SKIP_BELOW  = 100;
    localparam int TRACK_DIST  = 2500;
    localparam int TRACK_AFTER = 100;
    localparam int FOUND_MIN   = 500;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STATS,
        ST_SENSOR,
        ST_DIV1,
        ST_SQUARE,
        ST_ACCUM,
        ST_POSDIV,
        ST_FINISH,
        ST_OUT
    } lsnp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture scan
        logic stats;      // min/max/sum reduce
        logic sel_first;  // clear sensor index / accumulators
        logic div_start;  // start divider
        logic sq_scale;   // register s*s over full scale (reciprocal multiply)
        logic div_pos;    // divide weighted by total
        logic square;     // register s*s
        logic accum;      // fold current sensor into totals
        logic next_sensor;
        logic finish;     // update last position, build result
    } lsnp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic need_div;   // current sensor needs the calibration divide
        logic last_sensor;
        logic found;
    } lsnp_stat_t;

endpackage

// ----- design/lsnp_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath.
module lsnp_div #(
    parameter int W = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ----- design/lsnp_ctrl.sv -----
// Controller state machine for the line sensor block.
// Depends on lsnp_pkg.
module lsnp_ctrl
    import lsnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  lsnp_stat_t  stat,
    output lsnp_cmd_t   cmd
);
    lsnp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STATS;
                end
            end
            ST_STATS:
            begin
                cmd.stats     = 1'b1;
                cmd.sel_first = 1'b1;
                state_next    = ST_SENSOR;
            end
            ST_SENSOR:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV1;
                end
                else
                    state_next = ST_ACCUM;
            end
            ST_DIV1:
            begin
                if (stat.div_done)
                begin
                    cmd.square = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.sq_scale = 1'b1;
                state_next   = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (stat.last_sensor)
                    state_next = ST_POSDIV;
                else
                begin
                    cmd.next_sensor = 1'b1;
                    state_next      = ST_SENSOR;
                end
            end
            ST_POSDIV:
            begin
                if (stat.found)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_pos   = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.div_pos = 1'b1;
                if (!stat.found || stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

// ----- design/lsnp_dp.sv -----
// Datapath: scan register, statistics, calibration, centroid sums.
// Depends on lsnp_pkg and lsnp_div.
module lsnp_dp
    import lsnp_pkg::*;
#(
    parameter int NUM_SENSORS  = 8,
    parameter int FULL_SCALE   = 4095,
    parameter int SENSOR_PITCH = 1000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [NUM_SENSORS*SAMPLE_W-1:0]   samples,
    input  logic [SAMPLE_W-1:0]               spread_max,
    input  logic [SAMPLE_W-1:0]               white_max,
    input  logic [SAMPLE_W-1:0]               black_min,
    input  logic [SAMPLE_W-1:0]               noise,
    input  logic signed [CFG_W-1:0]           dark_low,
    input  logic [CFG_W-1:0]                  dark_high,
    input  lsnp_cmd_t                         cmd,
    output lsnp_stat_t                        stat,
    output logic [POS_W-1:0]                  line_position,
    output logic                              line_found,
    output logic [CNT_W-1:0]                  active_count
);
    localparam int IW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int FSW   = $clog2(FULL_SCALE + 1);
    localparam int SUMW  = SAMPLE_W + $clog2(NUM_SENSORS + 1);
    localparam int TOTW  = FSW + $clog2(NUM_SENSORS + 1);
    localparam int MAXSP = (NUM_SENSORS - 1) * SENSOR_PITCH;
    localparam int SPW   = $clog2(MAXSP + 2);
    localparam int WW    = TOTW + SPW;
    localparam int DW    = (SAMPLE_W + FSW) > WW ? (SAMPLE_W + FSW) : WW;
    localparam int LPW   = (SPW > POS_W ? SPW : POS_W) + 1;
    // s*s / FULL_SCALE as multiply by rounded-up reciprocal, exact for s*s < 2^SQW
    localparam int SQW   = 2 * FSW;
    localparam int RK    = SQW + FSW;
    localparam int RMW   = SQW + 2;
    localparam int QW    = SQW + RMW - RK;
    localparam longint unsigned RM =
        ((64'd1 << RK) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    // scan average the same way, exact for sum < 2^SUMW
    localparam int AK    = SUMW + $clog2(NUM_SENSORS);
    localparam int AMW   = SUMW + 2;
    localparam longint unsigned AM =
        ((64'd1 << AK) + 64'(NUM_SENSORS) - 64'd1) / 64'(NUM_SENSORS);

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_CAL  = 2'd2;

    logic [SAMPLE_W-1:0] smp_reg [NUM_SENSORS];
    logic [SAMPLE_W-1:0] lo_reg, hi_reg;
    logic [1:0]          mode_reg;
    logic [IW-1:0]       idx_reg;
    logic [SPW-1:0]      spos_reg;
    logic [TOTW-1:0]     total_reg;
    logic [WW-1:0]       weighted_reg;
    logic [CNT_W-1:0]    active_reg;
    logic [SQW-1:0]      sq_reg;
    logic [FSW-1:0]      cal_reg;
    logic [POS_W-1:0]    last_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                found_reg;

    logic [SAMPLE_W-1:0] lo_c, hi_c, cur, spread, d;
    logic [SUMW-1:0]     sum_c;
    logic [SUMW+AMW-1:0] avg_prod;
    logic [SAMPLE_W-1:0] avg;
    logic [SQW+RMW-1:0]  sq_prod;
    logic [QW-1:0]       sq_quo;
    logic                uniform, in_win;
    logic [FSW-1:0]      val;
    logic [DW-1:0]       div_a, div_b, div_q;
    logic                div_done;
    logic [LPW-1:0]      gap;

    always_comb
    begin
        lo_c  = smp_reg[0];
        hi_c  = smp_reg[0];
        sum_c = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (smp_reg[i] < lo_c) lo_c = smp_reg[i];
            if (smp_reg[i] > hi_c) hi_c = smp_reg[i];
            sum_c = sum_c + SUMW'(smp_reg[i]);
        end
    end

    assign avg_prod = (SUMW+AMW)'(sum_c) * (SUMW+AMW)'(AM);
    assign avg      = SAMPLE_W'(avg_prod[SUMW+AMW-1:AK]);
    assign sq_prod  = (SQW+RMW)'(sq_reg) * (SQW+RMW)'(RM);
    assign sq_quo   = sq_prod[SQW+RMW-1:RK];
    assign spread   = hi_reg - lo_reg;
    assign cur      = smp_reg[idx_reg];
    assign d        = cur - lo_reg;
    assign uniform  = (hi_c - lo_c) < spread_max;
    assign in_win   = !($signed({1'b0, cur}) < dark_low) && ({1'b0, cur} <= dark_high);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            for (int i = 0; i < NUM_SENSORS; i++)
                smp_reg[i] <= samples[i*SAMPLE_W +: SAMPLE_W];
        if (cmd.stats)
        begin
            lo_reg <= lo_c;
            hi_reg <= hi_c;
            if (uniform && avg < white_max)
                mode_reg <= MODE_ZERO;
            else if (uniform && avg > black_min)
                mode_reg <= MODE_FULL;
            else if ((hi_c - lo_c) < noise || hi_c == lo_c)
                mode_reg <= MODE_ZERO;
            else
                mode_reg <= MODE_CAL;
        end
        if (cmd.square)
            sq_reg <= SQW'(div_q[FSW-1:0]) * SQW'(div_q[FSW-1:0]);
        if (cmd.sq_scale)
            cal_reg <= (sq_quo > QW'(FULL_SCALE)) ? FSW'(FULL_SCALE) : FSW'(sq_quo);
    end

    // sensor needs the divide: calibrating, in window, excess at or above noise floor
    assign stat.need_div = (mode_reg == MODE_CAL) && in_win && !(d < noise);

    always_comb
    begin
        div_a = DW'(d) * DW'(FULL_SCALE);
        div_b = DW'(spread);
        if (cmd.div_pos)
        begin
            div_a = DW'(weighted_reg);
            div_b = DW'(total_reg);
        end
    end

    lsnp_div #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.div_done = div_done;

    always_comb
    begin
        if (mode_reg == MODE_FULL)
            val = FSW'(FULL_SCALE);
        else if (stat.need_div)
            val = cal_reg;
        else
            val = '0;
        gap = (LPW'(spos_reg) > LPW'(last_reg))
            ? LPW'(spos_reg) - LPW'(last_reg) : LPW'(last_reg) - LPW'(spos_reg);
    end

    assign stat.last_sensor = (idx_reg == IW'(NUM_SENSORS - 1));
    assign stat.found       = total_reg >= TOTW'(FOUND_MIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= CENTER_POS;
            found_reg <= 1'b0;
            pos_reg   <= CENTER_POS;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.sel_first)
                idx_reg <= '0;
            else if (cmd.next_sensor)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.finish)
            begin
                found_reg <= stat.found;
                if (stat.found)
                begin
                    if (div_q > DW'(POS_MAX))
                    begin
                        last_reg <= POS_MAX;
                        pos_reg  <= POS_MAX;
                    end
                    else
                    begin
                        last_reg <= POS_W'(div_q);
                        pos_reg  <= POS_W'(div_q);
                    end
                end
                else
                    pos_reg <= last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel_first)
        begin
            spos_reg     <= '0;
            total_reg    <= '0;
            weighted_reg <= '0;
            active_reg   <= '0;
        end
        else
        begin
            if (cmd.next_sensor)
                spos_reg <= SPW'(spos_reg + SPW'(SENSOR_PITCH));
            if (cmd.accum && !(val < FSW'(SKIP_BELOW)))
            begin
                if (!(gap > LPW'(TRACK_DIST) && total_reg > TOTW'(TRACK_AFTER)))
                begin
                    total_reg    <= total_reg + TOTW'(val);
                    weighted_reg <= weighted_reg + WW'(val) * WW'(spos_reg);
                    active_reg   <= active_reg + 1'b1;
                end
            end
        end
    end

    assign line_position = pos_reg;
    assign line_found    = found_reg;
    assign active_count  = active_reg;
endmodule

// ----- design/line_sensor_normalize_and_position_top.sv -----
// Top level: config registers, controller and datapath.
// Depends on lsnp_pkg, lsnp_ctrl, lsnp_dp and the assertion header.
//
// channel  dir  handshake              payload
// s_axis   in   s_axis_tvalid/tready   tdata: sample_0..sample_N-1
// m_axis   out  m_axis_tvalid/tready   tdata: line_position, line_found, active_count
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// One scan per request, one sensor at a time through one shared restoring divider.
// Calibrated sensor: SENSOR, DIV1, SQUARE, ACCUM; other sensor: SENSOR, ACCUM.
// Position divide (DW=29 bits for N=8) only when a line is found.
// Reset: config registers to defaults, last position to 3500.
// Output holds while m_axis_tready is low; no new scan until the result is taken.
`include "line_sensor_normalize_and_position_top_assert.svh"
module line_sensor_normalize_and_position_top
    import lsnp_pkg::*;
#(
    parameter int NUM_SENSORS  = 8,
    parameter int FULL_SCALE   = 4095,
    parameter int SENSOR_PITCH = 1000
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // sample_0 (lowest) .. sample_N-1, 12 bits each, zero fill
    input  logic [((NUM_SENSORS*SAMPLE_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // line_position [12:0], line_found [13], active_count [17:14], zero fill
    output logic [23:0]              m_axis_tdata,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);
    logic [SAMPLE_W-1:0]     spread_max_reg, white_max_reg, black_min_reg, noise_reg;
    logic signed [CFG_W-1:0] dark_low_reg;
    logic [CFG_W-1:0]        dark_high_reg;
    lsnp_cmd_t               cmd;
    lsnp_stat_t              stat;
    logic [POS_W-1:0]        line_position;
    logic                    line_found;
    logic [CNT_W-1:0]        active_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_max_reg <= 12'd740;
            white_max_reg  <= 12'd840;
            black_min_reg  <= 12'd3060;
            noise_reg      <= 12'd555;
            dark_low_reg   <= 13'sd3200;
            dark_high_reg  <= 13'd3900;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPREAD_MAX: spread_max_reg <= cfg_data[SAMPLE_W-1:0];
                REG_WHITE_MAX:  white_max_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_BLACK_MIN:  black_min_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_NOISE:      noise_reg      <= cfg_data[SAMPLE_W-1:0];
                REG_DARK_LOW:   dark_low_reg   <= cfg_data;
                REG_DARK_HIGH:  dark_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    lsnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lsnp_dp #(
        .NUM_SENSORS  (NUM_SENSORS),
        .FULL_SCALE   (FULL_SCALE),
        .SENSOR_PITCH (SENSOR_PITCH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (s_axis_tdata[NUM_SENSORS*SAMPLE_W-1:0]),
        .spread_max    (spread_max_reg),
        .white_max     (white_max_reg),
        .black_min     (black_min_reg),
        .noise         (noise_reg),
        .dark_low      (dark_low_reg),
        .dark_high     (dark_high_reg),
        .cmd           (cmd),
        .stat          (stat),
        .line_position (line_position),
        .line_found    (line_found),
        .active_count  (active_count)
    );

    assign m_axis_tdata = {6'd0, active_count, line_found, line_position};

    `LSNP_ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready, "ready while result pending")
    `LSNP_ASSERT_IMP(a_cnt_range, m_axis_tvalid, active_count <= CNT_W'(NUM_SENSORS), "bad count")
    `LSNP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

// ----- tb/lsnp_checker.sv -----
// Checker for the line sensor normalize and position block: watches the scan and
// result channels, predicts each result and compares. Depends on lsnp_pkg.
`timescale 1ns / 1ps
module lsnp_checker
    import lsnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [95:0] s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [23:0] m_data,
    input  logic        cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [3:0]       active;
        logic             found;
        logic [POS_W-1:0] pos;
    } line_result_t;

    localparam longint FS = 4095;

    logic [11:0] spread_max, white_max, black_min, noise;
    logic signed [12:0] dark_low;
    logic [12:0] dark_high;
    logic [12:0] track_pos;
    line_result_t expected_q[$];

    function automatic line_result_t locate_line(input logic [95:0] scan);
        longint smp[8];
        longint cal[8];
        longint lo, hi, sum, avg, spread, d, s, val, spos, gap, total, weighted;
        int active;
        line_result_t r;
        lo = scan[11:0];
        hi = lo;
        sum = 0;
        for (int i = 0; i < 8; i++)
        begin
            smp[i] = scan[i*12 +: 12];
            if (smp[i] < lo) lo = smp[i];
            if (smp[i] > hi) hi = smp[i];
            sum += smp[i];
            cal[i] = 0;
        end
        avg = sum / 8;
        spread = hi - lo;
        if (spread < spread_max && avg < white_max)
            ;
        else if (spread < spread_max && avg > black_min)
        begin
            for (int i = 0; i < 8; i++) cal[i] = FS;
        end
        else if (!(spread < noise || spread == 0))
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (smp[i] < longint'(dark_low) || smp[i] > dark_high) continue;
                d = smp[i] - lo;
                if (d < noise) continue;
                s = d * FS / spread;
                s = s * s / FS;
                cal[i] = (s > FS) ? FS : s;
            end
        end
        total = 0;
        weighted = 0;
        active = 0;
        for (int i = 0; i < 8; i++)
        begin
            val = cal[i];
            spos = i * 1000;
            if (val < SKIP_BELOW) continue;
            gap = (spos > track_pos) ? spos - track_pos : track_pos - spos;
            if (gap > TRACK_DIST && total > TRACK_AFTER) val = 0;
            total += val;
            weighted += val * spos;
            if (val > 0) active++;
        end
        r.found = (total >= FOUND_MIN);
        if (r.found)
            track_pos = (weighted / total > 8191) ? POS_MAX : 13'(weighted / total);
        r.pos = track_pos;
        r.active = 4'(active);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t got, exp_r;
        if (!rst_n)
        begin
            spread_max <= 12'd740;
            white_max  <= 12'd840;
            black_min  <= 12'd3060;
            noise      <= 12'd555;
            dark_low   <= 13'sd3200;
            dark_high  <= 13'd3900;
            track_pos  = CENTER_POS;
            fail_count <= 0;
            pending    <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SPREAD_MAX: spread_max <= cfg_data[11:0];
                    REG_WHITE_MAX:  white_max  <= cfg_data[11:0];
                    REG_BLACK_MIN:  black_min  <= cfg_data[11:0];
                    REG_NOISE:      noise      <= cfg_data[11:0];
                    REG_DARK_LOW:   dark_low   <= cfg_data;
                    REG_DARK_HIGH:  dark_high  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.push_back(locate_line(s_data));
            if (m_valid && m_ready)
            begin
                got = m_data[17:0];
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", m_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r || m_data[23:18] !== 6'd0)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: pos %0d/%0d found %0d/%0d active %0d/%0d",
                                exp_r.pos, got.pos, exp_r.found, got.found,
                                exp_r.active, got.active);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

// ----- tb/line_sensor_normalize_and_position_top_tb.sv -----
// Testbench top: drives scans and register writes, stalls both channels and
// gives the verdict. Depends on lsnp_pkg, lsnp_checker and the block.
`timescale 1ns / 1ps
module line_sensor_normalize_and_position_top_tb;
    import lsnp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_SPREAD_MAX;
    logic [CFG_W-1:0] cfg_data = '0;
    int fail_count, pending;
    int send_idle_pct = 0, recv_stall_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    line_sensor_normalize_and_position_top dut (.*);

    lsnp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // tvalid stays high after the accept; the next idle cycle or drain drops it
    task automatic send_scan(input logic [95:0] scan);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= scan;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (900) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [95:0] uniform_scan(input int base, input int jitter);
        logic [95:0] scan;
        for (int i = 0; i < 8; i++)
            scan[i*12 +: 12] = 12'(base + $urandom_range(jitter));
        return scan;
    endfunction

    // a dark line near one sensor over a light background, random width
    function automatic logic [95:0] line_scan(input int center);
        logic [95:0] scan;
        int span;
        for (int i = 0; i < 8; i++)
        begin
            span = (i > center) ? i - center : center - i;
            if (span == 0)
                scan[i*12 +: 12] = 12'($urandom_range(3100, 3950));
            else if (span == 1 && $urandom_range(1))
                scan[i*12 +: 12] = 12'($urandom_range(1500, 3700));
            else
                scan[i*12 +: 12] = 12'($urandom_range(100, 1200));
        end
        return scan;
    endfunction

    task automatic random_phase(input int count);
        int center;
        center = $urandom_range(7);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 2)
                center = $urandom_range(7);
            else if ($urandom_range(3) == 0)
                center = (center == 7) ? 6 : (center == 0 ? 1 : center + ($urandom_range(1) ? 1 : -1));
            case ($urandom_range(9))
                0: send_scan({$urandom, $urandom, $urandom});
                1: send_scan(uniform_scan($urandom_range(3500), 600));
                default: send_scan(line_scan(center));
            endcase
        end
    endtask

    initial
    begin
        #5000000;
        $display("line_sensor_normalize_and_position_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, uniform light and dark, both-uniform, tracking
        send_scan('0);
        send_scan({8{12'hFFF}});
        send_scan({8{12'd3500}});
        send_scan({8{12'd2000}});
        send_scan({12'hFFF, {7{12'h000}}});
        send_scan({{7{12'h000}}, 12'hFFF});
        send_scan({12'd3500, {6{12'd200}}, 12'd3500});
        send_scan({12'd3600, {5{12'd300}}, 12'd3800, 12'd300});
        send_scan({{6{12'd300}}, 12'd3900, 12'd3200});
        send_scan({12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555});
        for (int c = 0; c < 8; c++)
            send_scan(line_scan(c));
        // pause until everything has come back
        drain();
        // both uniform tests true; zero spread with zero noise floor
        write_reg(REG_SPREAD_MAX, 13'd4095);
        write_reg(REG_WHITE_MAX, 13'd2000);
        write_reg(REG_BLACK_MIN, 13'd0);
        write_reg(REG_NOISE, 13'd0);
        write_reg(REG_DARK_LOW, 13'h1DA8);   // -600
        write_reg(REG_DARK_HIGH, 13'd4195);
        send_scan({8{12'd100}});
        send_scan({8{12'd3000}});
        drain();
        write_reg(REG_SPREAD_MAX, 13'd0);
        write_reg(REG_WHITE_MAX, 13'd0);
        write_reg(REG_BLACK_MIN, 13'd4095);
        send_scan({8{12'd1234}});
        send_scan({12'd4095, {6{12'd0}}, 12'd1});
        drain();
        // empty dark window, index beyond the list
        write_reg(REG_DARK_LOW, 13'd4095);
        write_reg(REG_DARK_HIGH, 13'd100);
        write_reg(REG_UNUSED, 13'h1FFF);
        send_scan(line_scan(3));
        drain();

        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(230);
        drain();
        write_reg(REG_SPREAD_MAX, 13'd740);
        write_reg(REG_WHITE_MAX, 13'd840);
        write_reg(REG_BLACK_MIN, 13'd3060);
        write_reg(REG_NOISE, 13'd555);
        write_reg(REG_DARK_LOW, 13'd3000);
        write_reg(REG_DARK_HIGH, 13'd4195);
        send_idle_pct = 69; recv_stall_pct = 0;  random_phase(230);
        drain();
        write_reg(REG_NOISE, 13'd4095);
        write_reg(REG_DARK_LOW, 13'h1FFF);
        send_idle_pct = 0;  recv_stall_pct = 69; random_phase(80);
        drain();
        write_reg(REG_NOISE, 13'd200);
        write_reg(REG_SPREAD_MAX, 13'd300);
        write_reg(REG_DARK_LOW, 13'd1400);
        send_idle_pct = 0;  recv_stall_pct = 69; random_phase(150);
        drain();
        write_reg(REG_DARK_LOW, 13'd3200);
        write_reg(REG_DARK_HIGH, 13'd3900);
        write_reg(REG_NOISE, 13'd555);
        send_idle_pct = 20; recv_stall_pct = 20; random_phase(230);
        drain();

        if (fail_count == 0)
            $display("line_sensor_normalize_and_position_top_tb OK");
        else
            $display("line_sensor_normalize_and_position_top_tb NOT OK");
        $finish;
    end
endmodule
